### src/sqbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqbg_pkg: shared definitions of the queued sine beep generator
// Field widths, command and register codes, the command record passed from
// the front end to the back end, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package sqbg_pkg;

   // sizes
   localparam int QUEUE_DEPTH     = 8;
   localparam int MAX_BURST       = 64;
   localparam int SINE_TABLE_SIZE = 1024;
   localparam int CMD_FIFO_DEPTH  = 2;

   // item fields
   localparam int HZ_W     = 15;
   localparam int DUR_W    = 16;
   localparam int CNT_W    = 7;
   localparam int SAMPLE_W = 16;

   // registers
   localparam int RATE_W    = 17;
   localparam int PPH_W     = 20;
   localparam int AMP_W     = 15;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [RATE_W-1:0] SAMPLE_RATE_RST  = RATE_W'(44100);
   localparam logic [PPH_W-1:0]  PHASE_PER_HZ_RST = PPH_W'(97392);
   localparam logic [AMP_W-1:0]  AMPLITUDE_RST    = AMP_W'(28000);

   // stream packing, first field in the low bits
   localparam int HZ_LSB      = 0;
   localparam int DUR_LSB     = HZ_LSB + HZ_W;
   localparam int CNT_LSB     = DUR_LSB + DUR_W;
   localparam int REQ_TDATA_W = ((HZ_W + DUR_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = SAMPLE_W;
   localparam int RSP_TUSER_W = 2;
   localparam int TUSER_DROP  = 0;
   localparam int TUSER_PLAY  = 1;

   // millisecond to sample conversion
   localparam int MS_PER_S   = 1000;
   localparam int PROD_W     = DUR_W + RATE_W;
   localparam int LEN_W      = 24;  // 65535 * 131071 / 1000 < 2**24
   // 1000 = 8 * 125: shift out the 8, multiply by the rounded-up 1/125
   localparam int MS_PRE_SH  = 3;
   localparam int MS_ODD     = MS_PER_S >> MS_PRE_SH;
   localparam int DIVQ_W     = PROD_W - MS_PRE_SH;
   localparam int RECIP_SH   = DIVQ_W + $clog2(MS_ODD);
   localparam int RECIP_W    = RECIP_SH - $clog2(MS_ODD) + 1;
   localparam int RPROD_W    = DIVQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(MS_ODD) - 64'd1) / 64'(MS_ODD));

   // beep queue
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

   // phase accumulator and sine lookup
   localparam int PHASE_W = 32;
   localparam int STEP_W  = HZ_W + PPH_W;
   localparam int TAB_AW  = $clog2(SINE_TABLE_SIZE);
   localparam int QUARTER = SINE_TABLE_SIZE / 4;
   localparam int HALF    = SINE_TABLE_SIZE / 2;
   localparam int QIDX_W  = $clog2(QUARTER + 1);
   localparam int Q_W     = 15;
   localparam int Q_FRAC  = 15;
   localparam int MAG_W   = AMP_W + Q_W - Q_FRAC;

   typedef enum logic {
      CMD_ENQ   = 1'b0,
      CMD_BURST = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_RATE  = 2'd0,
      CSR_PHASE_PER_HZ = 2'd1,
      CSR_AMPLITUDE    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [RATE_W-1:0] sample_rate;
      logic [PPH_W-1:0]  phase_per_hz;
      logic [AMP_W-1:0]  amplitude;
   } csr_type;

   // one classified command, front end to back end
   typedef struct packed {
      cmd_type            kind;
      logic [HZ_W-1:0]    hz;
      logic [LEN_W-1:0]   len;    // beep length in samples (enqueue)
      logic [CNT_W-1:0]   count;  // samples to emit, already clipped (burst)
   } beep_cmd_type;

   // ---- quarter-wave sine table, unsigned Q0.15, built at elaboration ----
   localparam logic [63:0] TWO_PI_Q30     = 64'd6746518852;
   localparam logic [63:0] Q30_HALF_ROUND = 64'd16384;
   localparam logic [63:0] Q15_MAX        = 64'd32767;
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [Q_W-1:0] qsine_tab_type [0:QUARTER];

   function automatic qsine_tab_type build_qsine();
      qsine_tab_type tab;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [63:0]   v;
      for (int j = 0; j <= QUARTER; j++) begin
         x    = (64'(j) * TWO_PI_Q30) / SINE_TABLE_SIZE;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + Q30_HALF_ROUND) >> 15;
         if (v > Q15_MAX) begin
            v = Q15_MAX;
         end
         tab[j] = v[Q_W-1:0];
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE_TAB = build_qsine();

endpackage
`default_nettype wire

### src/sqbg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqbg_front: request intake and classification
// Takes request items, converts beep milliseconds to samples with a
// multiply and a registered reciprocal multiply for the divide by 1000,
// clips burst counts, and pushes one command record to the command queue.
// ----------------------------------------------------------------------------
module sqbg_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sqbg_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic [sqbg_pkg::RATE_W-1:0]      sample_rate,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output sqbg_pkg::beep_cmd_type           cmd_data
);
   import sqbg_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCALE,
      F_PUSH
   } fstate_type;

   fstate_type              state_ff, state_in;
   beep_cmd_type            cmd_ff, cmd_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;

   logic [HZ_W-1:0]         f_hz;
   logic [DUR_W-1:0]        f_dur;
   logic [CNT_W-1:0]        f_cnt;
   logic [PROD_W-1:0]       prod;
   logic [RPROD_W-1:0]      recip_prod;

   assign f_hz  = req_tdata[HZ_LSB +: HZ_W];
   assign f_dur = req_tdata[DUR_LSB +: DUR_W];
   assign f_cnt = req_tdata[CNT_LSB +: CNT_W];
   assign prod  = f_dur * sample_rate;

   // divide by 1000: drop the factor 8 by a shift, then multiply by the
   // rounded-up reciprocal of 125; exact over the whole product range
   assign recip_prod = prod_ff[PROD_W-1:MS_PRE_SH] * RECIP_M;

   assign req_tready = (state_ff == F_IDLE);
   assign cmd_valid  = (state_ff == F_PUSH);
   assign cmd_data   = cmd_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               cmd_in.kind  = cmd_type'(req_tuser);
               cmd_in.hz    = f_hz;
               cmd_in.len   = '0;
               cmd_in.count = (f_cnt > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : f_cnt;
               if (cmd_type'(req_tuser) == CMD_ENQ) begin
                  prod_in  = prod;
                  state_in = F_SCALE;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_SCALE: begin
            cmd_in.len = recip_prod[RECIP_SH +: LEN_W];
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

### src/sqbg_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqbg_cmd_fifo: short command queue between front end and back end
// Register-based FIFO of command records; lets either side stall alone.
// ----------------------------------------------------------------------------
module sqbg_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   output logic                   wr_ready,
   input  sqbg_pkg::beep_cmd_type wr_data,
   output logic                   rd_valid,
   input  logic                   rd_ready,
   output sqbg_pkg::beep_cmd_type rd_data
);
   import sqbg_pkg::*;

   localparam int CF_PTR_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CF_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   beep_cmd_type          fifo_mem_ff [CMD_FIFO_DEPTH];
   logic [CF_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CF_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CF_CNT_W-1:0]   count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign wr_ready = (count_ff != CF_CNT_W'(CMD_FIFO_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = fifo_mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         fifo_mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

### src/sqbg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqbg_back: beep queue, phase accumulator and sample pipeline
// Executes commands: enqueue into the beep queue with one status item on rsp,
// or play a burst of samples through a table lookup stage and a multiply
// stage into the output register.
// ----------------------------------------------------------------------------
module sqbg_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  sqbg_pkg::beep_cmd_type           cmd_data,
   input  sqbg_pkg::csr_type                csr,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sqbg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   output logic [sqbg_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import sqbg_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ENQ,
      B_BURST
   } bstate_type;

   // command sequencer
   bstate_type             state_ff, state_in;
   beep_cmd_type           cur_ff, cur_in;
   logic [CNT_W-1:0]       left_ff, left_in;

   // beep queue
   logic [HZ_W-1:0]        hz_q_ff  [QUEUE_DEPTH];
   logic [LEN_W-1:0]       rem_q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      head_ff, head_in;
   logic [QPTR_W-1:0]      tail_ff, tail_in;
   logic [QFILL_W-1:0]     fill_ff, fill_in;
   logic                   q_we;
   logic [QPTR_W-1:0]      q_waddr;
   logic [HZ_W-1:0]        q_whz;
   logic [LEN_W-1:0]       q_wrem;

   // phase
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [PHASE_W-1:0]     step_ff;
   logic                   stale_ff, stale_in;

   // lookup stage
   logic                   b_valid_ff, b_valid_in;
   logic [Q_W-1:0]         b_q_ff, b_q_in;
   logic                   b_neg_ff, b_neg_in;
   logic                   b_last_ff, b_last_in;
   logic                   b_drop_ff, b_drop_in;
   logic                   b_play_ff, b_play_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]    out_sample_ff, out_sample_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_drop_ff, out_drop_in;
   logic                   out_play_ff, out_play_in;

   logic                   out_free;
   logic                   b_move;
   logic                   b_free;
   logic                   q_empty;
   logic                   q_full;
   logic                   head_change;
   logic [HZ_W-1:0]        head_hz;
   logic [LEN_W-1:0]       head_rem;
   logic [LEN_W-1:0]       rem_dec;
   logic [STEP_W-1:0]      step_prod;
   logic [TAB_AW-1:0]      tab_idx;
   logic [TAB_AW-2:0]      half_idx;
   logic [TAB_AW-1:0]      mirror_idx;
   logic [QIDX_W-1:0]      q_idx;
   logic [AMP_W+Q_W-1:0]   amp_prod;
   logic [MAG_W-1:0]       mag;

   assign out_free = !out_valid_ff || rsp_tready;
   assign b_move   = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;
   assign q_empty  = (fill_ff == '0);
   assign q_full   = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign head_hz  = hz_q_ff[head_ff];
   assign head_rem = rem_q_ff[head_ff];
   assign rem_dec  = head_rem - 1'b1;

   // phase step of the head beep, reloaded every cycle
   assign step_prod = head_hz * csr.phase_per_hz;

   // quarter-wave addressing from the top phase bits
   assign tab_idx    = phase_ff[PHASE_W-1 -: TAB_AW];
   assign half_idx   = tab_idx[TAB_AW-2:0];
   assign mirror_idx = TAB_AW'(HALF) - {1'b0, half_idx};
   assign q_idx      = ({1'b0, half_idx} > TAB_AW'(QUARTER)) ? QIDX_W'(mirror_idx)
                                                              : QIDX_W'({1'b0, half_idx});

   assign cmd_ready = (state_ff == B_IDLE);

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      phase_in    = phase_ff;
      head_change = 1'b0;
      q_we        = 1'b0;
      q_waddr     = tail_ff;
      q_whz       = cur_ff.hz;
      q_wrem      = cur_ff.len;
      b_valid_in  = b_move ? 1'b0 : b_valid_ff;
      b_q_in      = b_q_ff;
      b_neg_in    = b_neg_ff;
      b_last_in   = b_last_ff;
      b_drop_in   = b_drop_ff;
      b_play_in   = b_play_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cur_in  = cmd_data;
               left_in = cmd_data.count;
               if (cmd_data.kind == CMD_ENQ) begin
                  state_in = B_ENQ;
               end else if (cmd_data.count != '0) begin
                  state_in = B_BURST;
               end
            end
         end
         B_ENQ: begin
            if (b_free) begin
               b_valid_in = 1'b1;
               b_q_in     = '0;
               b_neg_in   = 1'b0;
               b_last_in  = 1'b1;
               b_play_in  = 1'b0;
               b_drop_in  = (cur_ff.len != '0) && q_full;
               if ((cur_ff.len != '0) && !q_full) begin
                  q_we        = 1'b1;
                  tail_in     = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in     = fill_ff + 1'b1;
                  head_change = q_empty;
               end
               state_in = B_IDLE;
            end
         end
         B_BURST: begin
            if (b_free && (q_empty || !stale_ff)) begin
               b_valid_in = 1'b1;
               b_last_in  = (left_ff == CNT_W'(1));
               b_drop_in  = 1'b0;
               b_play_in  = !q_empty;
               b_q_in     = q_empty ? '0 : QSINE_TAB[q_idx];
               b_neg_in   = !q_empty && tab_idx[TAB_AW-1];
               if (!q_empty) begin
                  phase_in = phase_ff + step_ff;
                  if (rem_dec == '0) begin
                     head_in     = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     fill_in     = fill_ff - 1'b1;
                     head_change = 1'b1;
                  end else begin
                     q_we    = 1'b1;
                     q_waddr = head_ff;
                     q_whz   = head_hz;
                     q_wrem  = rem_dec;
                  end
               end
               left_in = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      stale_in = head_change;
   end

   // scale by amplitude, truncate toward zero, restore sign
   assign amp_prod = csr.amplitude * b_q_ff;
   assign mag      = amp_prod[AMP_W+Q_W-1:Q_FRAC];

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      out_drop_in   = out_drop_ff;
      out_play_in   = out_play_ff;
      if (b_move) begin
         out_valid_in  = 1'b1;
         out_sample_in = b_neg_ff ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
         out_last_in   = b_last_ff;
         out_drop_in   = b_drop_ff;
         out_play_in   = b_play_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid            = out_valid_ff;
   assign rsp_tdata             = out_sample_ff;
   assign rsp_tlast             = out_last_ff;
   assign rsp_tuser[TUSER_DROP] = out_drop_ff;
   assign rsp_tuser[TUSER_PLAY] = out_play_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         left_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         stale_ff     <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         stale_ff     <= stale_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff        <= cur_in;
      step_ff       <= step_prod[PHASE_W-1:0];
      b_q_ff        <= b_q_in;
      b_neg_ff      <= b_neg_in;
      b_last_ff     <= b_last_in;
      b_drop_ff     <= b_drop_in;
      b_play_ff     <= b_play_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
      out_drop_ff   <= out_drop_in;
      out_play_ff   <= out_play_in;
      if (q_we) begin
         hz_q_ff[q_waddr]  <= q_whz;
         rem_q_ff[q_waddr] <= q_wrem;
      end
   end

   // ---- assertions ----
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("beep queue fill above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == QFILL_W'(QUEUE_DEPTH)) |-> (head_ff == tail_ff))
      else $error("queue pointers disagree with fill");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_play_ff) |-> (out_sample_ff == '0))
      else $error("silent item carries a nonzero sample");

endmodule
`default_nettype wire

### src/queued_sine_beep_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// queued_sine_beep_generator_core: queued DDS sine beep generator
// Enqueues beeps (tone, length) and plays them as signed sine samples on
// burst requests, one beep after another.
// ----------------------------------------------------------------------------
//
// channel | dir | handshake         | payload
// --------+-----+-------------------+-----------------------------------------
// req     | in  | tvalid / tready   | tuser: cmd; tdata: tone_hz, duration_ms,
//         |     |                   |        sample_count
// rsp     | out | tvalid / tready   | tdata: sample; tlast: last;
//         |     |                   | tuser: dropped, playing
// csr     | in  | we (no wait)      | index, wdata
//
// Enqueue item: the ms-to-samples conversion is a product register plus a
//   reciprocal multiply stage before the command queue.
// Burst item of N samples: samples follow one per cycle while rsp is not
//   stalled, with a pause for the phase step reload each time the head beep
//   changes.
// Reset is synchronous; queue contents need no clearing pass.
// A stalled rsp side halts the back end only; the 2-entry command queue
//   lets the front end keep accepting and converting items meanwhile.
//
module queued_sine_beep_generator_core (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [sqbg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sqbg_pkg::CSR_W-1:0]       csr_wdata,
   // request items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [14:0] tone_hz, [30:15] duration_ms, [37:31] sample_count, rest zero
   input  logic [sqbg_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                             req_tuser,
   // result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] sample
   output logic [sqbg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   // [0] dropped, [1] playing
   output logic [sqbg_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import sqbg_pkg::*;

   csr_type       csr_ff;
   beep_cmd_type  fe_cmd;
   logic          fe_valid;
   logic          fe_ready;
   beep_cmd_type  be_cmd;
   logic          be_valid;
   logic          be_ready;

   // config registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sample_rate  <= SAMPLE_RATE_RST;
         csr_ff.phase_per_hz <= PHASE_PER_HZ_RST;
         csr_ff.amplitude    <= AMPLITUDE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE:  csr_ff.sample_rate  <= csr_wdata[RATE_W-1:0];
            CSR_PHASE_PER_HZ: csr_ff.phase_per_hz <= csr_wdata[PPH_W-1:0];
            CSR_AMPLITUDE:    csr_ff.amplitude    <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // front end: intake, ms-to-samples conversion, burst clipping
   sqbg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .sample_rate (csr_ff.sample_rate),
      .cmd_valid   (fe_valid),
      .cmd_ready   (fe_ready),
      .cmd_data    (fe_cmd)
   );

   // decoupling queue
   sqbg_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_ready (fe_ready),
      .wr_data  (fe_cmd),
      .rd_valid (be_valid),
      .rd_ready (be_ready),
      .rd_data  (be_cmd)
   );

   // back end: beep queue, phase accumulator, sample pipeline
   sqbg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (be_valid),
      .cmd_ready  (be_ready),
      .cmd_data   (be_cmd),
      .csr        (csr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the queued sine beep generator core
// Drives enqueue and burst items on the req stream and checks every sample
// on the rsp stream against an in-bench DDS model with its own beep queue,
// phase accumulator and sine table. A short directed table comes first,
// then random traffic in phases with different register settings and
// different amounts of idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import sqbg_pkg::*;

   // register values right after reset
   localparam logic [16:0] RATE_AT_RESET = 17'd44100;
   localparam logic [19:0] STEP_AT_RESET = 20'd97392;
   localparam logic [14:0] AMP_AT_RESET  = 15'd28000;

   // index with no register behind it, writes there are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam longint unsigned TURN_Q30 = 64'd6746518852;  // 2*pi in Q30

   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_LIMIT = 50000;
   localparam int SETTLE      = 150;  // > longest burst plus lead-in
   localparam int SHOW_MAX    = 10;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                dropped;
      logic                playing;
   } beep_out_type;

   // one row of the directed table; t_* fields used only when typed is set
   typedef struct {
      cmd_type          cmd;
      logic [HZ_W-1:0]  hz;
      logic [DUR_W-1:0] dur;
      logic [CNT_W-1:0] cnt;
      bit               typed;
      logic [SAMPLE_W-1:0] t_sample;
      bit               t_drop;
      bit               t_play;
   } beep_row_type;

   localparam int N_ROWS = 24;

   // default registers: 44100 samples/s, so 1 ms gives 44 samples
   beep_row_type dir_rows [N_ROWS] = '{
      '{CMD_BURST, 15'd0,     16'd0,     7'd4,   1'b1, 16'd0, 1'b0, 1'b0}, // silent burst
      '{CMD_BURST, 15'd0,     16'd0,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0}, // no items
      '{CMD_ENQ,   15'd0,     16'd0,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0}, // zero length
      '{CMD_BURST, 15'd0,     16'd0,     7'd127, 1'b1, 16'd0, 1'b0, 1'b0}, // clipped, silent
      '{CMD_ENQ,   15'd1000,  16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd440,   16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd24000, 16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd32767, 16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd0,     16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd12345, 16'd2,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd7,     16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_ENQ,   15'd1,     16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0}, // queue full now
      '{CMD_ENQ,   15'd24000, 16'd65535, 7'd0,   1'b1, 16'd0, 1'b1, 1'b0}, // full: dropped
      '{CMD_ENQ,   15'd5,     16'd0,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0}, // zero wins over full
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd1,   1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd63,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd64,  1'b0, 16'd0, 1'b0, 1'b0}, // drained
      '{CMD_ENQ,   15'd440,   16'd1,     7'd0,   1'b1, 16'd0, 1'b0, 1'b0},
      '{CMD_BURST, 15'd0,     16'd0,     7'd127, 1'b0, 16'd0, 1'b0, 1'b0}  // clipped, plays
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]       csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [14:0] tone_hz, [30:15] duration_ms,
                                        // [37:31] sample_count, rest zero
   logic                   req_tuser;   // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [15:0] sample
   logic                   rsp_tlast;
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [0] dropped, [1] playing

   // model state
   int               sine_lut [SINE_TABLE_SIZE];
   logic [HZ_W-1:0]  beep_hz   [QUEUE_DEPTH];
   int unsigned      beep_left [QUEUE_DEPTH];
   int unsigned      q_head;
   int unsigned      q_tail;
   int unsigned      q_fill;
   logic [31:0]      wave_ph;
   logic [16:0]      cfg_rate;
   logic [19:0]      cfg_step;
   logic [14:0]      cfg_amp;

   beep_out_type     burst_buf [MAX_BURST];  // samples of the item just accepted
   beep_out_type     samples_due [$];        // expected rsp items, oldest first

   int               mismatches;
   int               src_gap_pct;
   int               snk_stall_pct;
   int               cycles;

   queued_sine_beep_generator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- sine table: Q1.15, first quadrant by a Taylor series in Q30 ----
   function automatic int quarter_wave(longint unsigned j);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned v;
      ang  = (j * TURN_Q30) / SINE_TABLE_SIZE;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      v = (acc + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return int'(v);
   endfunction

   function automatic void build_sine_lut();
      longint unsigned j;
      bit              neg;
      for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
         j   = k;
         neg = 1'b0;
         if (2 * j >= SINE_TABLE_SIZE) begin
            j   = j - SINE_TABLE_SIZE / 2;
            neg = 1'b1;
         end
         if (4 * j > SINE_TABLE_SIZE) begin
            j = SINE_TABLE_SIZE / 2 - j;
         end
         sine_lut[k] = neg ? -quarter_wave(j) : quarter_wave(j);
      end
   endfunction

   // ---- model of one accepted item; fills burst_buf, returns its size ----
   function automatic int synth_samples(cmd_type c, logic [HZ_W-1:0] hz,
                                        logic [DUR_W-1:0] dur, logic [CNT_W-1:0] cnt);
      longint unsigned len;
      longint          s;
      int              n;
      int unsigned     idx;
      if (c == CMD_ENQ) begin
         len = (64'(dur) * 64'(cfg_rate)) / 1000;
         burst_buf[0] = '{sample: '0, last: 1'b1, dropped: 1'b0, playing: 1'b0};
         if (len != 0) begin
            if (q_fill >= QUEUE_DEPTH) begin
               burst_buf[0].dropped = 1'b1;
            end else begin
               beep_hz[q_tail]   = hz;
               beep_left[q_tail] = int'(len);
               q_tail = (q_tail + 1) % QUEUE_DEPTH;
               q_fill++;
            end
         end
         return 1;
      end
      n = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
      for (int i = 0; i < n; i++) begin
         s = 0;
         burst_buf[i].playing = 1'b0;
         if (q_fill != 0) begin
            idx = int'((64'(wave_ph) * SINE_TABLE_SIZE) >> 32);
            s = (longint'(cfg_amp) * longint'(sine_lut[idx])) / 32768;
            burst_buf[i].playing = 1'b1;
            wave_ph = wave_ph + 32'(64'(beep_hz[q_head]) * 64'(cfg_step));
            if (beep_left[q_head] > 0) begin
               beep_left[q_head]--;
            end
            if (beep_left[q_head] == 0) begin
               q_head = (q_head + 1) % QUEUE_DEPTH;
               q_fill--;
            end
         end
         burst_buf[i].sample  = s[SAMPLE_W-1:0];
         burst_buf[i].last    = (i + 1 == n);
         burst_buf[i].dropped = 1'b0;
      end
      return n;
   endfunction

   // ---- one req item: random gap, hold until accepted, then predict ----
   task automatic send_item(input cmd_type c, input logic [HZ_W-1:0] hz,
                            input logic [DUR_W-1:0] dur, input logic [CNT_W-1:0] cnt,
                            input bit typed, input logic [SAMPLE_W-1:0] t_sample,
                            input bit t_drop, input bit t_play);
      int           n;
      beep_out_type r;
      while ($urandom_range(0, 99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= REQ_TDATA_W'({cnt, dur, hz});
      do begin
         @(posedge clock);
      end while (!req_tready);
      n = synth_samples(c, hz, dur, cnt);
      for (int i = 0; i < n; i++) begin
         r = burst_buf[i];
         // directed rows with a typed result override the model's fields
         if (typed) begin
            r.sample  = t_sample;
            r.dropped = t_drop;
            r.playing = t_play;
         end
         samples_due.push_back(r);
      end
   endtask

   // ---- stop sending, wait out every expected item, then let it settle ----
   task automatic drain(input int settle);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (samples_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (samples_due.size() != 0) begin
         $display("%0d expected sample items never arrived", samples_due.size());
         mismatches += samples_due.size();
         samples_due.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   // ---- register writes, block idle; one write per clock ----
   task automatic load_regs(input logic [CSR_W-1:0] rate, input logic [CSR_W-1:0] step,
                            input logic [CSR_W-1:0] amp, input bit poke_spare);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [CSR_W-1:0]     val [4];
      int                   n;
      idx = '{CSR_SAMPLE_RATE, CSR_PHASE_PER_HZ, CSR_AMPLITUDE, CSR_SPARE};
      val = '{rate, step, amp, 20'hFFFFF};
      n   = poke_spare ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         case (idx[i])
            CSR_SAMPLE_RATE:  cfg_rate = val[i][16:0];
            CSR_PHASE_PER_HZ: cfg_step = val[i][19:0];
            CSR_AMPLITUDE:    cfg_amp  = val[i][14:0];
            default: ;  // spare index: nothing changes
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // ---- random traffic, enqueue and burst mixed ----
   task automatic run_phase(input int n_items, input int gap_pct, input int stall_pct,
                            input bit hold_mid);
      cmd_type          c;
      logic [HZ_W-1:0]  hz;
      logic [DUR_W-1:0] dur;
      logic [CNT_W-1:0] cnt;
      int               pick;
      src_gap_pct   = gap_pct;
      snk_stall_pct = stall_pct;
      for (int k = 0; k < n_items; k++) begin
         // sender holds off until the whole backlog is out
         if (hold_mid && k == n_items / 2) begin
            drain(0);
         end
         hz  = HZ_W'($urandom);
         dur = DUR_W'($urandom);
         cnt = CNT_W'($urandom);
         if ($urandom_range(0, 99) < 40) begin
            c = CMD_ENQ;
            if ($urandom_range(0, 7) != 0) begin
               hz = HZ_W'($urandom_range(0, 24000));
            end
            // short beeps keep the queue moving; any length once it is full
            if (q_fill < QUEUE_DEPTH) begin
               dur = ($urandom_range(0, 7) == 0) ? '0 : DUR_W'($urandom_range(1, 4));
            end
         end else begin
            c    = CMD_BURST;
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
               cnt = '0;
            end else if (pick == 1) begin
               cnt = CNT_W'($urandom_range(MAX_BURST + 1, 127));
            end else begin
               cnt = CNT_W'($urandom_range(1, MAX_BURST));
            end
         end
         send_item(c, hz, dur, cnt, 1'b0, '0, 1'b0, 1'b0);
      end
      drain(SETTLE);
   endtask

   // ---- rsp side: random stalls, every accepted item checked in order ----
   always @(posedge clock) begin : sample_monitor
      beep_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (samples_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_MAX) begin
                  $display("unexpected item: sample %h last %b user %b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end else begin
               want = samples_due.pop_front();
               if (rsp_tdata !== want.sample || rsp_tlast !== want.last ||
                   rsp_tuser[TUSER_DROP] !== want.dropped ||
                   rsp_tuser[TUSER_PLAY] !== want.playing) begin
                  mismatches++;
                  if (mismatches <= SHOW_MAX) begin
                     $display("mismatch: sample %h last %b drop %b play %b, want %h %b %b %b",
                              rsp_tdata, rsp_tlast, rsp_tuser[TUSER_DROP],
                              rsp_tuser[TUSER_PLAY], want.sample, want.last,
                              want.dropped, want.playing);
                  end
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // ---- watchdog ----
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("queued_sine_beep_generator_core verification failed");
      $finish;
   end

   // ---- main sequence ----
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      mismatches    = 0;
      src_gap_pct   = 0;
      snk_stall_pct = 0;
      build_sine_lut();
      cfg_rate = RATE_AT_RESET;
      cfg_step = STEP_AT_RESET;
      cfg_amp  = AMP_AT_RESET;
      q_head   = 0;
      q_tail   = 0;
      q_fill   = 0;
      wave_ph  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings, no idling
      for (int r = 0; r < N_ROWS; r++) begin
         send_item(dir_rows[r].cmd, dir_rows[r].hz, dir_rows[r].dur, dir_rows[r].cnt,
                   dir_rows[r].typed, dir_rows[r].t_sample, dir_rows[r].t_drop,
                   dir_rows[r].t_play);
      end
      drain(SETTLE);

      // fastest rate, full amplitude, no idling
      load_regs(20'd96000, 20'd44739, 20'd32767, 1'b0);
      run_phase(52, 0, 0, 1'b0);

      // slowest rate, largest step, silent amplitude; spare index poked
      load_regs(20'd8000, 20'd536871, 20'd0, 1'b1);
      run_phase(52, 76, 0, 1'b1);

      // smallest step and amplitude, receiver stalling
      load_regs(20'd44100, 20'd1, 20'd1, 1'b0);
      run_phase(52, 0, 76, 1'b0);

      // random settings, light idling on both sides
      load_regs(20'($urandom_range(8000, 96000)), 20'($urandom),
                20'($urandom_range(0, 32767)), 1'b0);
      run_phase(52, 14, 14, 1'b0);

      if (mismatches == 0) begin
         $display("queued_sine_beep_generator_core verification clean");
      end else begin
         $display("queued_sine_beep_generator_core verification failed");
      end
      $finish;
   end

endmodule

### files.f
src/sqbg_pkg.sv
src/sqbg_front.sv
src/sqbg_cmd_fifo.sv
src/sqbg_back.sv
src/queued_sine_beep_generator_core.sv
verif/tb_top.sv
